// ===== hdl/vertex_transform_backface_cull_defines.svh =====
// assertion macros for the vertex transform block
`ifndef VERTEX_TRANSFORM_BACKFACE_CULL_DEFINES_SVH
`define VERTEX_TRANSFORM_BACKFACE_CULL_DEFINES_SVH
`ifndef SYNTHESIS
`define VTB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VTB_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VTB_ASSERT(label, clk, rst_n, prop, msg)
`define VTB_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== hdl/vtb_pkg.sv =====
// shared types and constants for the vertex transform block
`timescale 1ns / 1ps
`default_nettype none
package vtb_pkg;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgW = 64;
  localparam int unsigned InDataW = 128;
  localparam int unsigned OutDataW = 160;
  localparam logic signed [31:0] SatMax = 32'sh7fffffff;
  localparam logic signed [31:0] SatMin = 32'sh80000000;

  // one transformed corner
  typedef struct packed {
    logic [15:0]        v;
    logic [15:0]        u;
    logic signed [31:0] w;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } corner_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic signed [31:0] r;
    begin
      if (v > 80'sh7fffffff) r = SatMax;
      else if (v < -80'sh80000000) r = SatMin;
      else r = v[31:0];
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ===== hdl/vtb_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle, signed with saturation
`timescale 1ns / 1ps
`default_nettype none
module vtb_div #(
  parameter int unsigned FracBits = vtb_pkg::FracBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);
  import vtb_pkg::*;
  localparam int unsigned NumW = 32 + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [32:0]     rem_q, rem_d;
  logic [31:0]     den_q, den_d;
  logic            neg_q, neg_d;
  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [33:0]     trial;
  logic [32:0]     shifted;
  logic signed [NumW:0] sq;

  // one shift-subtract step per cycle
  always_comb begin
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    neg_d = neg_q; busy_d = busy_q; cnt_d = cnt_q; done_o = 1'b0;
    shifted = {rem_q[31:0], num_q[NumW-1]};
    trial = {1'b0, shifted} - {2'b00, den_q};
    if (start_i) begin
      num_d = (num_i[31] ? NumW'(-$signed({{FracBits{1'b1}}, num_i})) :
              NumW'({{FracBits{1'b0}}, num_i})) << FracBits;
      den_d = den_i[31] ? 32'(-den_i) : den_i;
      neg_d = num_i[31] ^ den_i[31];
      rem_d = '0; quo_d = '0; cnt_d = CntW'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (!trial[33]) begin
        rem_d = trial[32:0]; quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted; quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_o = 1'b1;
      end
    end
  end

  // apply sign and saturate
  assign sq = neg_q ? -$signed({1'b0, quo_d}) : $signed({1'b0, quo_d});
  assign quo_o = sat32(80'(sq));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end
endmodule
`default_nettype wire

// ===== hdl/vertex_transform_backface_cull.sv =====
// vertex transform, perspective divide and back-face cull, top level
// Usage: corners arrive as s_axis beats (pos x,y,z, tex u,v); results
// leave on m_axis, three beats per kept triangle in reverse corner
// order, tlast on the third. Matrix rows are written through cfg_we_i /
// cfg_idx_i / cfg_data_i; the user must write them only while no corner is in
// flight, as the block does not enforce it. All eight indexes are used, two
// per row. One shared 33x33 multiplier does the sixteen matrix products (a
// multiply phase, then an accumulate phase each) and the two cross products;
// one shared bit-serial divider does the three divides, each a start state
// and then one shift-subtract step per quotient bit (32+FRAC_BITS bits); with
// w zero each divide skips the divider wait. The third corner then passes two
// cross multiply states and a cull state, and a kept triangle then gives the
// three output beats. s_axis_tready is high only while idle, so a new corner
// is not taken until the last one is through. When the receiver stalls the
// current output beat holds and no new corner is taken. Reset restores the
// identity matrix, clears the corner count and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module vertex_transform_backface_cull #(
  parameter int unsigned FRAC_BITS = vtb_pkg::FracBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [vtb_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  wire logic [vtb_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v
  input  wire logic [vtb_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // ndc_x, ndc_y, ndc_z, clip_w, out_u, out_v
  output logic [vtb_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic                              m_axis_tlast
);
  import vtb_pkg::*;
  `include "vertex_transform_backface_cull_defines.svh"

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMul  = 4'd1;
  localparam logic [3:0] StDivS = 4'd2;
  localparam logic [3:0] StDivW = 4'd3;
  localparam logic [3:0] StRoute = 4'd4;
  localparam logic [3:0] StCr0  = 4'd5;
  localparam logic [3:0] StCr1  = 4'd6;
  localparam logic [3:0] StCull = 4'd7;
  localparam logic [3:0] StOut  = 4'd8;

  localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

  logic [CfgW-1:0] regs_q [NumRegs];
  logic [3:0]  st_q, st_d;
  logic [3:0]  k_q;          // product index, row*4+col
  logic [1:0]  dk_q;         // divide index
  logic [1:0]  cc_q;         // corner count
  logic [1:0]  oc_q;         // output beat
  logic        ph_q;         // product phase: multiply, then accumulate
  logic signed [31:0] vec_q [3];
  logic [15:0] u_q, v_q;
  logic signed [81:0] acc_q; // exact sum of four products
  logic signed [31:0] clip_q [4];
  logic signed [31:0] ndc_q [3];
  corner_t held_q [2];
  corner_t cur;
  logic signed [65:0] prod_q, cr0_q;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [31:0] elem, vsel;
  logic [CfgW-1:0] reg_sel;
  logic        div_start, div_done;
  logic signed [31:0] div_q;
  logic signed [81:0] acc_n, fl;
  logic signed [32:0] e02x, e01y, e02y, e01x;
  logic signed [67:0] crz;

  // shared multiplier operands
  assign reg_sel = regs_q[{k_q[3:2], k_q[1]}];
  assign elem = k_q[0] ? reg_sel[63:32] : reg_sel[31:0];
  assign vsel = (k_q[1:0] == 2'd3) ? One : vec_q[k_q[1:0]];
  assign e02x = 33'(cur.x) - 33'(held_q[0].x);
  assign e01y = 33'(held_q[1].y) - 33'(held_q[0].y);
  assign e02y = 33'(cur.y) - 33'(held_q[0].y);
  assign e01x = 33'(held_q[1].x) - 33'(held_q[0].x);
  always_comb begin
    unique case (st_q)
      StCr0:   begin ma = e02x; mb = e01y; end
      StCr1:   begin ma = e02y; mb = e01x; end
      default: begin ma = 33'(elem); mb = 33'(vsel); end
    endcase
  end
  assign mp = ma * mb;

  assign acc_n = acc_q + 82'(prod_q);
  assign fl = acc_n >>> FRAC_BITS;
  assign crz = 68'(cr0_q) - 68'(prod_q);
  assign cur = '{v: v_q, u: u_q, w: clip_q[3], z: ndc_q[2], y: ndc_q[1], x: ndc_q[0]};

  assign div_start = (st_q == StDivS);
  vtb_div #(.FracBits(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i(clip_q[dk_q]), .den_i(clip_q[3]),
    .done_o(div_done), .quo_o(div_q)
  );

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (s_axis_tvalid) st_d = StMul;
      StMul:   if (k_q == 4'd15 && ph_q) st_d = StDivS;
      StDivS:  st_d = StDivW;
      StDivW:  if (div_done || clip_q[3] == '0) st_d = (dk_q == 2'd2) ? StRoute : StDivS;
      StRoute: st_d = (cc_q == 2'd2) ? StCr0 : StIdle;
      StCr0:   st_d = StCr1;
      StCr1:   st_d = StCull;
      StCull:  st_d = crz[67] ? StIdle : StOut;
      StOut:   if (m_axis_tready && oc_q == 2'd2) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tlast = (oc_q == 2'd2);
  always_comb begin
    unique case (oc_q)
      2'd0:    m_axis_tdata = cur;
      2'd1:    m_axis_tdata = held_q[1];
      default: m_axis_tdata = held_q[0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; k_q <= '0; dk_q <= '0; cc_q <= '0; oc_q <= '0; ph_q <= 1'b0;
      regs_q[0] <= 64'd65536;           regs_q[1] <= '0;
      regs_q[2] <= 64'd65536 << 32;     regs_q[3] <= '0;
      regs_q[4] <= '0;                  regs_q[5] <= 64'd65536;
      regs_q[6] <= '0;                  regs_q[7] <= 64'd65536 << 32;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) regs_q[cfg_idx_i] <= cfg_data_i;
      unique case (st_q)
        StIdle: begin k_q <= '0; dk_q <= '0; oc_q <= '0; ph_q <= 1'b0; end
        StMul: begin
          ph_q <= ~ph_q;
          if (ph_q) k_q <= k_q + 1'b1;
        end
        StDivW: if (div_done || clip_q[3] == '0) dk_q <= dk_q + 1'b1;
        StRoute: cc_q <= (cc_q == 2'd2) ? 2'd0 : cc_q + 1'b1;
        StOut: if (m_axis_tready) oc_q <= oc_q + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && s_axis_tvalid) begin
      vec_q[0] <= s_axis_tdata[31:0];
      vec_q[1] <= s_axis_tdata[63:32];
      vec_q[2] <= s_axis_tdata[95:64];
      u_q <= s_axis_tdata[111:96];
      v_q <= s_axis_tdata[127:112];
      acc_q <= '0;
    end
    if (st_q == StMul) begin
      if (!ph_q) prod_q <= mp;
      else if (k_q[1:0] == 2'd3) begin
        clip_q[k_q[3:2]] <= sat32(80'(fl));
        acc_q <= '0;
      end else acc_q <= acc_n;
    end
    if (st_q == StDivW) begin
      if (clip_q[3] == '0)
        ndc_q[dk_q] <= (clip_q[dk_q] == '0) ? '0 : (clip_q[dk_q][31] ? SatMin : SatMax);
      else if (div_done) ndc_q[dk_q] <= div_q;
    end
    if (st_q == StRoute && cc_q != 2'd2) held_q[cc_q[0]] <= cur;
    if (st_q == StCr0) prod_q <= mp;
    if (st_q == StCr1) begin cr0_q <= prod_q; prod_q <= mp; end
  end

  `VTB_ASSERT(a_out_only_third, clk_i, rst_ni, m_axis_tvalid |-> cc_q == 2'd0, "output while mid triangle")
  `VTB_ASSERT(a_ready_idle, clk_i, rst_ni, s_axis_tready |-> !m_axis_tvalid, "input taken during output")
  `VTB_ASSERT(a_cnt_range, clk_i, rst_ni, cc_q != 2'd3, "corner count out of range")
  `VTB_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |=> st_q == StIdle || $past(rst_ni), "not idle after reset")
endmodule
`default_nettype wire

// ===== tb/vertex_transform_backface_cull_chk.sv =====
// checker for the vertex transform block: predicts kept triangles and compares output beats
`timescale 1ns / 1ps
`default_nettype none
module vertex_transform_backface_cull_chk #(
  parameter int unsigned FRAC_BITS = vtb_pkg::FracBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [vtb_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  wire logic [vtb_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                         s_axis_tvalid,
  input  wire logic                         s_axis_tready,
  input  wire logic [vtb_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  input  wire logic [vtb_pkg::OutDataW-1:0] m_axis_tdata,
  input  wire logic                         m_axis_tlast,
  output int                                fail_cnt_o,
  output int                                pending_o
);
  import vtb_pkg::*;

  typedef struct packed {
    corner_t c;
    logic    last;
  } out_beat_t;

  logic [CfgW-1:0] mvp_q [NumRegs];
  int unsigned     corner_cnt_q;
  corner_t         held_q [2];
  out_beat_t       expected_q [$];
  int              fails = 0;

  assign pending_o = expected_q.size();
  assign fail_cnt_o = fails;

  // floor shift of a signed value
  function automatic logic signed [79:0] shr_floor(input logic signed [79:0] v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic logic signed [79:0] mat_elem(input int r, input int c);
    logic [CfgW-1:0] rg;
    rg = mvp_q[2 * r + c / 2];
    return (c % 2) ? 80'(signed'(rg[63:32])) : 80'(signed'(rg[31:0]));
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [79:0] v);
    if (v > 80'sh7fffffff) return 32'sh7fffffff;
    if (v < -80'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // one row of the matrix times (x, y, z, 1); the exact sum floors the same
  function automatic logic signed [31:0] row_dot(input int r,
                                                 input logic signed [79:0] vec [4]);
    logic signed [79:0] acc;
    acc = 0;
    for (int c = 0; c < 4; c++) acc += mat_elem(r, c) * vec[c];
    return sat(shr_floor(acc));
  endfunction

  function automatic logic signed [31:0] persp(input logic signed [31:0] c,
                                               input logic signed [31:0] w);
    logic signed [79:0] n, d;
    if (w == 0) return (c > 0) ? SatMax : (c < 0) ? SatMin : 32'sd0;
    n = 80'(c) <<< FRAC_BITS;
    d = 80'(w);
    return sat(n / d);
  endfunction

  function automatic corner_t transform(input logic [InDataW-1:0] d);
    logic signed [79:0] vec [4];
    corner_t k;
    logic signed [31:0] cx, cy, cz;
    vec[0] = 80'(signed'(d[31:0]));
    vec[1] = 80'(signed'(d[63:32]));
    vec[2] = 80'(signed'(d[95:64]));
    vec[3] = 80'sd1 <<< FRAC_BITS;
    cx = row_dot(0, vec);
    cy = row_dot(1, vec);
    cz = row_dot(2, vec);
    k.w = row_dot(3, vec);
    k.x = persp(cx, k.w);
    k.y = persp(cy, k.w);
    k.z = persp(cz, k.w);
    k.u = d[111:96];
    k.v = d[127:112];
    return k;
  endfunction

  // queue one predicted output beat
  function automatic void expect_beat(input corner_t kc, input logic kl);
    out_beat_t b;
    b.c = kc;
    b.last = kl;
    expected_q.insert(expected_q.size(), b);
  endfunction

  // predict, on each accepted corner
  always @(posedge clk_i or negedge rst_ni) begin
    corner_t k, p0, p1;
    logic signed [79:0] crs;
    if (!rst_ni) begin
      mvp_q[0] = 64'd65536;
      mvp_q[1] = 0;
      mvp_q[2] = 64'd65536 << 32;
      mvp_q[3] = 0;
      mvp_q[4] = 0;
      mvp_q[5] = 64'd65536;
      mvp_q[6] = 0;
      mvp_q[7] = 64'd65536 << 32;
      corner_cnt_q = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i && cfg_idx_i < NumRegs) mvp_q[cfg_idx_i] = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        k = transform(s_axis_tdata);
        if (corner_cnt_q < 2) begin
          held_q[corner_cnt_q] = k;
          corner_cnt_q++;
        end else begin
          corner_cnt_q = 0;
          p0 = held_q[0];
          p1 = held_q[1];
          crs = (80'(k.x) - 80'(p0.x)) * (80'(p1.y) - 80'(p0.y))
              - (80'(k.y) - 80'(p0.y)) * (80'(p1.x) - 80'(p0.x));
          if (crs >= 0) begin
            expect_beat(k, 1'b0);
            expect_beat(p1, 1'b0);
            expect_beat(p0, 1'b1);
          end
        end
      end
    end
  end

  // compare each output beat with the oldest expected one
  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected beat %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata !== e.c || m_axis_tlast !== e.last) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: exp %h last %b, got %h last %b",
                     e.c, e.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/vertex_transform_backface_cull_tb.sv =====
// testbench top: stimulus, stall phases and verdict for the vertex transform block
`timescale 1ns / 1ps
`default_nettype none
module vertex_transform_backface_cull_tb;
  import vtb_pkg::*;

  typedef enum int {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_mode_e;
  localparam int WatchLimit = 20000;
  localparam int HoldLen = 600;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [RegIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tlast;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  int fail_cnt, pending;
  idle_mode_e mode;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int hold_off = 0;
  int idle_cycles = 0;

  vertex_transform_backface_cull dut (.*);
  vertex_transform_backface_cull_chk chk (.*, .fail_cnt_o(fail_cnt), .pending_o(pending));

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver readiness per phase, with a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_off <= HoldLen - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (mode == IdleRecv) m_axis_tready <= ($urandom_range(99) >= 52);
    else if (mode == IdleBoth) m_axis_tready <= ($urandom_range(99) >= 15);
    else m_axis_tready <= 1'b1;
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  // offer one corner; valid stays up until the next idle gap or drain
  task automatic send_corner(input logic [31:0] x, y, z, input logic [15:0] u, v);
    int sp;
    sp = (mode == IdleSend) ? 52 : (mode == IdleBoth) ? 15 : 0;
    while ($urandom_range(99) < sp) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {v, u, z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
  endtask

  task automatic write_reg(input int idx, input logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegIdxW'(idx);
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // q16.16 matrix with small random entries (extreme ones when asked), often an identity-like w row
  task automatic load_matrix(input bit extreme);
    logic [31:0] e [4][4];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        e[r][c] = extreme ? (($urandom_range(1)) ? 32'h7fffffff : 32'h80000000)
                          : 32'($signed($urandom_range(6 << 16)) - (3 << 16));
    if (!extreme && $urandom_range(3) != 0) begin
      e[3][0] = 0; e[3][1] = 0; e[3][2] = 0;
      e[3][3] = 32'($urandom_range(1 << 16, 3 << 16));
    end
    for (int r = 0; r < 4; r++) begin
      write_reg(2 * r, {e[r][1], e[r][0]});
      write_reg(2 * r + 1, {e[r][3], e[r][2]});
    end
  endtask

  task automatic random_tris(input int n);
    for (int i = 0; i < n; i++)
      send_corner(rand_coord(), rand_coord(), rand_coord(), 16'($urandom()), 16'($urandom()));
  endtask

  initial begin
    rst_ni = 0;
    cfg_we_i = 0; cfg_idx_i = 0; cfg_data_i = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0;
    mode = IdleNone;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: identity, counter-clockwise and clockwise, degenerate, extremes
    send_corner(0, 0, 0, 16'h0000, 16'hffff);
    send_corner(32'h10000, 0, 32'h8000, 16'hffff, 16'h0000);
    send_corner(0, 32'h10000, 32'hffff0000, 16'h1234, 16'h5678);
    send_corner(0, 0, 0, 1, 2);
    send_corner(0, 32'h10000, 0, 3, 4);
    send_corner(32'h10000, 0, 0, 5, 6);
    send_corner(5, 5, 5, 0, 0);
    send_corner(5, 5, 5, 0, 0);
    send_corner(5, 5, 5, 16'hffff, 16'hffff);
    send_corner(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'hffff, 0);
    send_corner(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 16'hffff);
    send_corner(32'hffffffff, 32'hffffffff, 0, 16'haaaa, 16'h5555);
    drain();
    // zero w row: division by zero with positive, negative and zero numerators
    for (int r = 0; r < 3; r++) write_reg(6, 0);
    write_reg(7, 0);
    send_corner(32'h10000, 32'hffff0000, 0, 1, 1);
    send_corner(32'hffff0000, 0, 32'h10000, 2, 2);
    send_corner(0, 32'h10000, 32'hffff0000, 3, 3);
    drain();
    write_reg(7, 64'h0001_0000_0000_0000);
    // out-of-range index is absent (three index bits cover all eight)

    // random phases with a new matrix each time, extremes in one
    for (int ph = 0; ph < 8; ph++) begin
      mode = idle_mode_e'(ph % 4);
      load_matrix(ph == 5);
      if (ph == 2) hold_go = ~hold_go;
      random_tris(36);
      drain();
    end
    // back to identity for the last stretch
    write_reg(0, 64'd65536); write_reg(1, 0); write_reg(2, 64'd65536 << 32);
    write_reg(3, 0); write_reg(4, 0); write_reg(5, 64'd65536);
    write_reg(6, 0); write_reg(7, 64'd65536 << 32);
    mode = IdleBoth;
    random_tris(9);
    drain();

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
